/* rtl/rwla_pkg.sv */
// ---------------------------------------------------------------------------
// rwla_pkg: shared types and codes for the readers-writer lock arbiter
// Transaction payloads, operation / action / result codes and cell controls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rwla_pkg;

  localparam int CLIENT_W = 4;

  // operation codes
  localparam logic [2:0] OP_REQ_WRITE = 3'd0;
  localparam logic [2:0] OP_REQ_READ  = 3'd1;
  localparam logic [2:0] OP_RELEASE   = 3'd2;
  localparam logic [2:0] OP_FINISH    = 3'd3;
  localparam logic [2:0] OP_CHECK     = 3'd4;
  localparam logic [2:0] OP_UPDATE    = 3'd5;

  // check actions
  localparam logic [2:0] ACT_BEGIN_WRITE = 3'd0;
  localparam logic [2:0] ACT_BEGIN_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE       = 3'd2;
  localparam logic [2:0] ACT_READ        = 3'd3;
  localparam logic [2:0] ACT_END         = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_GRANT  = 2'd0;
  localparam logic [1:0] KIND_CHECK  = 2'd1;
  localparam logic [1:0] KIND_QFULL  = 2'd2;

  typedef struct packed {
    logic [2:0]          op;
    logic [CLIENT_W-1:0] client;
    logic [2:0]          action;
  } rwla_in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [CLIENT_W-1:0] client_res;
    logic                grant_write;
    logic                allowed;
    logic                last;
  } rwla_out_t;

  // broadcast control to the per-client cells
  typedef struct packed {
    logic clr;       // release: clear selected client's active, finished and pending bits
    logic fin;       // mark selected client finished
    logic pend;      // add selected client to pending readers
    logic grant_wr;  // head writer takes the lock
    logic grant_rd;  // all pending readers take the lock, load the grant chain
    logic shift;     // advance the grant chain by one client
  } rd_ctl_t;

  // per-cell control for the writer queue
  typedef struct packed {
    logic load;      // take the pushed client
    logic shift;     // take the neighbor's entry (removal at or below this cell)
  } wq_ctl_t;

endpackage

`default_nettype wire

/* rtl/rwla_wq_cell.sv */
// ---------------------------------------------------------------------------
// rwla_wq_cell: one writer queue slot
// Holds one queued client; closes gaps by taking its upper neighbor's entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwla_wq_cell (
  input  logic                           clk,
  input  rwla_pkg::wq_ctl_t              ctl,
  input  logic [rwla_pkg::CLIENT_W-1:0]  key,
  input  logic [rwla_pkg::CLIENT_W-1:0]  nb_entry,
  output logic [rwla_pkg::CLIENT_W-1:0]  entry,
  output logic                           match
);
  import rwla_pkg::*;

  logic [CLIENT_W-1:0] entry_r;
  logic [CLIENT_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = nb_entry;
    end else if (ctl.load) begin
      entry_nxt = key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (entry_r == key);

endmodule

`default_nettype wire

/* rtl/rwla_rd_cell.sv */
// ---------------------------------------------------------------------------
// rwla_rd_cell: per-client lock state
// Active, finished and pending-reader bits plus one stage of the grant chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwla_rd_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rwla_pkg::rd_ctl_t ctl,
  input  logic              sel,
  input  logic              hsel,
  input  logic              scan_in,
  output logic              active,
  output logic              finished,
  output logic              pending,
  output logic              scan
);
  import rwla_pkg::*;

  logic active_r, active_nxt;
  logic fin_r, fin_nxt;
  logic pend_r, pend_nxt;
  logic scan_r, scan_nxt;

  always_comb begin
    active_nxt = active_r;
    fin_nxt    = fin_r;
    pend_nxt   = pend_r;
    scan_nxt   = scan_r;
    if (ctl.clr && sel) begin
      active_nxt = 1'b0;
      fin_nxt    = 1'b0;
      pend_nxt   = 1'b0;
    end
    if (ctl.fin && sel) begin
      fin_nxt = 1'b1;
    end
    if (ctl.pend && sel) begin
      pend_nxt = 1'b1;
    end
    if (ctl.grant_wr && hsel) begin
      active_nxt = 1'b1;
      fin_nxt    = 1'b0;
    end
    if (ctl.grant_rd) begin
      scan_nxt = pend_r;
      pend_nxt = 1'b0;
      if (pend_r) begin
        active_nxt = 1'b1;
        fin_nxt    = 1'b0;
      end
    end else if (ctl.shift) begin
      scan_nxt = scan_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fin_r    <= 1'b0;
      pend_r   <= 1'b0;
      scan_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      fin_r    <= fin_nxt;
      pend_r   <= pend_nxt;
      scan_r   <= scan_nxt;
    end
  end

  assign active   = active_r;
  assign finished = fin_r;
  assign pending  = pend_r;
  assign scan     = scan_r;

endmodule

`default_nettype wire

/* rtl/readers_writer_lock_arbiter_top.sv */
// ---------------------------------------------------------------------------
// readers_writer_lock_arbiter_top: readers-writer lock arbiter
// Writer FIFO and per-client reader cells with read/write phase alternation.
//
//   channel | ports                   | handshake
//   --------+-------------------------+-------------------------------------
//   input   | start, busy, in_item    | taken when start && !busy
//   result  | out_valid, out_item     | one-cycle strobe, always taken
//
// A transaction is latched on accept and executed in the next cycle. Release
// and check scan the writer queue one slot per cycle. After the grant step a
// read grant shifts the reader chain one client per cycle. Reset (synchronous,
// rst_n low) clears all sets, the writer count and the phase; busy is high for
// the whole transaction. Results cannot be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module readers_writer_lock_arbiter_top #(
  parameter int NUM_CLIENTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rwla_pkg::rwla_in_t  in_item,
  output logic                out_valid,
  output rwla_pkg::rwla_out_t out_item
);
  import rwla_pkg::*;

  localparam int CW   = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CNTW = $clog2(NUM_CLIENTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_GRANT = 5'b01000,
    S_RDGR  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]          op_r, op_nxt;
  logic [CLIENT_W-1:0] c_r, c_nxt;
  logic [2:0]          act_r, act_nxt;

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0]   ridx_r, ridx_nxt;
  logic            lw_r, lw_nxt;

  logic      out_valid_r, out_valid_nxt;
  rwla_out_t out_item_r, out_item_nxt;

  // cell interfaces
  logic [NUM_CLIENTS-1:0] act_v, fin_v, pend_v, scan_v;
  logic [NUM_CLIENTS-1:0] sel_v, hsel_v, match_v;
  logic [CLIENT_W-1:0]    entry_v [NUM_CLIENTS];
  rd_ctl_t                rd_ctl;
  logic                   push_en, rm_en;
  logic [CNTW-1:0]        rm_ptr;

  logic [CW-1:0] c_idx, h_idx;
  logic          c_valid;
  logic          any_act;
  logic          a_bit, f_bit, p_bit;
  logic          scan_done, scan_hit;
  logic          is_rd, is_wr, allowed;
  logic          rd_last;

  assign c_idx   = CW'(c_r);
  assign h_idx   = CW'(entry_v[0]);
  assign c_valid = (32'(c_r) < NUM_CLIENTS);
  assign any_act = |act_v;
  assign a_bit   = c_valid && act_v[c_idx];
  assign f_bit   = fin_v[c_idx];
  assign p_bit   = c_valid && pend_v[c_idx];
  assign rd_last = ~|scan_v[NUM_CLIENTS-1:1];

  assign scan_done = (ptr_r == cnt_r);
  assign scan_hit  = !scan_done && match_v[ptr_r[CW-1:0]];

  // check answer; the queue lookup comes from the scan
  always_comb begin
    is_rd = (!lw_r && a_bit) || p_bit;
    is_wr = (lw_r && a_bit) || scan_hit;
    allowed = 1'b0;
    if (c_valid && !(a_bit && f_bit)) begin
      case (act_r)
        ACT_BEGIN_WRITE, ACT_BEGIN_READ: allowed = !is_rd && !is_wr;
        ACT_WRITE:                       allowed = (any_act && !lw_r) ? 1'b0 : a_bit;
        ACT_READ:                        allowed = a_bit;
        ACT_END:                         allowed = is_rd || is_wr;
        default:                         allowed = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    c_nxt         = c_r;
    act_nxt       = act_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    ridx_nxt      = ridx_r;
    lw_nxt        = lw_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_ctl        = '0;
    push_en       = 1'b0;
    rm_en         = 1'b0;
    rm_ptr        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.op;
          c_nxt     = in_item.client;
          act_nxt   = in_item.action;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_IDLE;
        ptr_nxt   = '0;
        case (op_r)
          OP_REQ_WRITE: begin
            if (c_valid) begin
              if (cnt_r == CNTW'(NUM_CLIENTS)) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{kind: KIND_QFULL, client_res: c_r, grant_write: 1'b0,
                                  allowed: 1'b0, last: 1'b1};
              end else begin
                push_en   = 1'b1;
                cnt_nxt   = cnt_r + CNTW'(1);
                state_nxt = S_GRANT;
              end
            end
          end
          OP_REQ_READ: begin
            if (c_valid) begin
              rd_ctl.pend = 1'b1;
              state_nxt   = S_GRANT;
            end
          end
          OP_RELEASE: begin
            // ignored while nobody holds the lock
            if (c_valid && any_act) begin
              rd_ctl.clr = 1'b1;
              state_nxt  = S_SCAN;
            end
          end
          OP_FINISH: begin
            if (a_bit) begin
              rd_ctl.fin = 1'b1;
            end
          end
          OP_CHECK:  state_nxt = S_SCAN;
          OP_UPDATE: state_nxt = S_GRANT;
          default:   state_nxt = S_IDLE;
        endcase
      end

      S_SCAN: begin
        if (op_r == OP_CHECK) begin
          if (scan_done || scan_hit) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{kind: KIND_CHECK, client_res: c_r, grant_write: 1'b0,
                              allowed: allowed, last: 1'b1};
            state_nxt     = S_IDLE;
          end else begin
            ptr_nxt = ptr_r + CNTW'(1);
          end
        end else begin
          if (scan_done) begin
            state_nxt = S_IDLE;
          end else if (scan_hit) begin
            rm_en     = 1'b1;
            rm_ptr    = ptr_r;
            cnt_nxt   = cnt_r - CNTW'(1);
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt = ptr_r + CNTW'(1);
          end
        end
      end

      S_GRANT: begin
        state_nxt = S_IDLE;
        if (!any_act) begin
          // after a read phase the writer goes first, after a write phase the readers
          if ((cnt_r != '0) && (!lw_r || (pend_v == '0))) begin
            rm_en           = 1'b1;
            rm_ptr          = '0;
            cnt_nxt         = cnt_r - CNTW'(1);
            rd_ctl.grant_wr = 1'b1;
            lw_nxt          = 1'b1;
            out_valid_nxt   = 1'b1;
            out_item_nxt    = '{kind: KIND_GRANT, client_res: entry_v[0], grant_write: 1'b1,
                                allowed: 1'b0, last: 1'b1};
          end else if (pend_v != '0) begin
            rd_ctl.grant_rd = 1'b1;
            lw_nxt          = 1'b0;
            ridx_nxt        = '0;
            state_nxt       = S_RDGR;
          end
        end
      end

      S_RDGR: begin
        rd_ctl.shift = 1'b1;
        ridx_nxt     = ridx_r + CW'(1);
        if (scan_v[0]) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_GRANT, client_res: CLIENT_W'(ridx_r),
                            grant_write: 1'b0, allowed: 1'b0, last: rd_last};
        end
        if (rd_last) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lw_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lw_r        <= lw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    c_r        <= c_nxt;
    act_r      <= act_nxt;
    ptr_r      <= ptr_nxt;
    ridx_r     <= ridx_nxt;
    out_item_r <= out_item_nxt;
  end

  genvar i;
  generate
    for (i = 0; i < NUM_CLIENTS; i++) begin : g_cell
      wq_ctl_t             wq_ctl;
      logic [CLIENT_W-1:0] nb;

      assign sel_v[i]     = c_valid && (c_idx == CW'(i));
      assign hsel_v[i]    = (h_idx == CW'(i));
      assign wq_ctl.load  = push_en && (cnt_r == CNTW'(i));
      assign wq_ctl.shift = rm_en && (CNTW'(i) >= rm_ptr);

      if (i < NUM_CLIENTS - 1) begin : g_mid
        assign nb = entry_v[i+1];
      end else begin : g_end
        assign nb = entry_v[i];
      end

      rwla_wq_cell u_wq (
        .clk      (clk),
        .ctl      (wq_ctl),
        .key      (c_r),
        .nb_entry (nb),
        .entry    (entry_v[i]),
        .match    (match_v[i])
      );

      rwla_rd_cell u_rd (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (rd_ctl),
        .sel      (sel_v[i]),
        .hsel     (hsel_v[i]),
        .scan_in  ((i < NUM_CLIENTS - 1) ? scan_v[(i < NUM_CLIENTS - 1) ? i + 1 : i] : 1'b0),
        .active   (act_v[i]),
        .finished (fin_v[i]),
        .pending  (pend_v[i]),
        .scan     (scan_v[i])
      );
    end
  endgenerate

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

/* tb/readers_writer_lock_arbiter_top_tb.sv */
// ---------------------------------------------------------------------------
// readers_writer_lock_arbiter_top_tb: self-checking bench for the RW lock arbiter
// Drives lock commands through the start/busy port and tracks the writer FIFO,
// pending readers, holders and the read/write phase in a local model. Every
// result strobe is compared field by field against the oldest predicted
// result. Directed cases are followed by a full reader burst, writer queue
// overflow and random traffic with random input gaps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module readers_writer_lock_arbiter_top_tb;
  import rwla_pkg::*;

  localparam int NCL          = 16;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 310;

  // codes with no name in the package
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [2:0] ACT_MAX      = 3'd7;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  logic      busy;
  rwla_in_t  in_item = '0;
  logic      out_valid;
  rwla_out_t out_item;

  readers_writer_lock_arbiter_top #(
    .NUM_CLIENTS(NCL)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- lock state tracking ----------------
  logic [NCL-1:0]      held_set;
  logic [NCL-1:0]      done_set;
  logic [NCL-1:0]      rd_wait;
  logic [CLIENT_W-1:0] wr_fifo [NCL];
  int                  wr_cnt;
  logic                write_phase;

  rwla_out_t lock_results_q[$];

  int max_gap = 4;
  int items_sent;
  int max_burst;
  int max_wr_cnt;
  int mismatches;
  int grants_seen;
  int checks_seen;
  int drops_seen;

  function automatic void push_result(logic [1:0] kind, logic [CLIENT_W-1:0] c,
                                      logic gw, logic ok);
    rwla_out_t r;
    r.kind        = kind;
    r.client_res  = c;
    r.grant_write = gw;
    r.allowed     = ok;
    r.last        = 1'b0;
    lock_results_q.insert(lock_results_q.size(), r);
  endfunction

  function automatic void grant_head_writer();
    logic [CLIENT_W-1:0] c;
    if (wr_cnt == 0) return;
    c = wr_fifo[0];
    for (int i = 1; i < wr_cnt; i++) wr_fifo[i-1] = wr_fifo[i];
    wr_cnt--;
    held_set[c] = 1'b1;
    done_set[c] = 1'b0;
    write_phase = 1'b1;
    push_result(KIND_GRANT, c, 1'b1, 1'b0);
  endfunction

  function automatic void grant_waiting_readers();
    if (rd_wait == 0) return;
    for (int c = 0; c < NCL; c++)
      if (rd_wait[c]) push_result(KIND_GRANT, c[CLIENT_W-1:0], 1'b0, 1'b0);
    held_set    = held_set | rd_wait;
    done_set    = done_set & ~rd_wait;
    rd_wait     = '0;
    write_phase = 1'b0;
  endfunction

  // phases alternate: after reads the writer goes first, after a write the readers
  function automatic void run_grant_step();
    int n0;
    if (held_set != 0) return;
    n0 = lock_results_q.size();
    if (!write_phase) begin
      grant_head_writer();
      if (lock_results_q.size() == n0) grant_waiting_readers();
    end else begin
      grant_waiting_readers();
      if (lock_results_q.size() == n0) grant_head_writer();
    end
  endfunction

  function automatic logic queued_writer(logic [CLIENT_W-1:0] c);
    for (int i = 0; i < wr_cnt; i++)
      if (wr_fifo[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic is_reader(logic [CLIENT_W-1:0] c);
    return (!write_phase && held_set[c]) || rd_wait[c];
  endfunction

  function automatic logic is_writer(logic [CLIENT_W-1:0] c);
    return (write_phase && held_set[c]) || queued_writer(c);
  endfunction

  function automatic logic check_allowed(logic [CLIENT_W-1:0] c, logic [2:0] act);
    logic holds;
    holds = held_set[c];
    if (holds && done_set[c]) return 1'b0;
    case (act)
      ACT_BEGIN_WRITE, ACT_BEGIN_READ: return !is_reader(c) && !is_writer(c);
      ACT_WRITE: return (held_set != 0 && !write_phase) ? 1'b0 : holds;
      ACT_READ:  return holds;
      ACT_END:   return is_reader(c) || is_writer(c);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void release_client(logic [CLIENT_W-1:0] c);
    int idx;
    if (held_set == 0) return;
    held_set[c] = 1'b0;
    done_set[c] = 1'b0;
    rd_wait[c]  = 1'b0;
    idx = -1;
    for (int i = 0; i < wr_cnt; i++)
      if (idx < 0 && wr_fifo[i] == c) idx = i;
    if (idx >= 0) begin
      for (int i = idx + 1; i < wr_cnt; i++) wr_fifo[i-1] = wr_fifo[i];
      wr_cnt--;
    end
  endfunction

  // update the lock state for one accepted command and queue its results
  function automatic void apply_lock_op(rwla_in_t it);
    int n0;
    int n;
    n0 = lock_results_q.size();
    case (it.op)
      OP_REQ_WRITE: begin
        if (wr_cnt >= NCL) begin
          push_result(KIND_QFULL, it.client, 1'b0, 1'b0);
        end else begin
          wr_fifo[wr_cnt] = it.client;
          wr_cnt++;
          run_grant_step();
        end
      end
      OP_REQ_READ: begin
        rd_wait[it.client] = 1'b1;
        run_grant_step();
      end
      OP_RELEASE: release_client(it.client);
      OP_FINISH:  if (held_set[it.client]) done_set[it.client] = 1'b1;
      OP_CHECK:   push_result(KIND_CHECK, it.client, 1'b0,
                              check_allowed(it.client, it.action));
      OP_UPDATE:  run_grant_step();
      default: ;
    endcase
    n = lock_results_q.size() - n0;
    if (n > 0) lock_results_q[lock_results_q.size()-1].last = 1'b1;
    if (n > max_burst) max_burst = n;
    if (wr_cnt > max_wr_cnt) max_wr_cnt = wr_cnt;
  endfunction

  // ---------------- stimulus ----------------
  // start stays high after a transaction; the next call lowers it before a gap, the end lowers it
  task automatic issue_op(input logic [2:0] op, input logic [CLIENT_W-1:0] cl,
                          input logic [2:0] act);
    rwla_in_t item;
    int       gap;
    item.op     = op;
    item.client = cl;
    item.action = act;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    apply_lock_op(item);
    items_sent++;
  endtask

  function automatic logic [CLIENT_W-1:0] pick_from(logic [NCL-1:0] pool);
    logic [CLIENT_W-1:0] c;
    c = CLIENT_W'($urandom);
    if (pool != 0)
      while (!pool[c]) c = c + CLIENT_W'(1);
    return c;
  endfunction

  task automatic test_basic_ops();
    issue_op(OP_CHECK,     4'd0,  ACT_BEGIN_WRITE);
    issue_op(OP_REQ_READ,  4'd0,  ACT_MAX);
    issue_op(OP_REQ_READ,  4'd15, ACT_BEGIN_WRITE);
    issue_op(OP_CHECK,     4'd15, ACT_END);
    issue_op(OP_CHECK,     4'd15, ACT_BEGIN_READ);
    issue_op(OP_FINISH,    4'd0,  ACT_BEGIN_WRITE);
    issue_op(OP_CHECK,     4'd0,  ACT_READ);
    issue_op(OP_FINISH,    4'd9,  ACT_BEGIN_WRITE);   // not a holder
    issue_op(OP_REQ_WRITE, 4'd3,  ACT_BEGIN_WRITE);
    issue_op(OP_REQ_WRITE, 4'd3,  ACT_BEGIN_WRITE);   // duplicate entry
    issue_op(OP_CHECK,     4'd3,  ACT_WRITE);
    issue_op(OP_RELEASE,   4'd0,  ACT_BEGIN_WRITE);   // lock now free, no grant yet
    issue_op(OP_RELEASE,   4'd7,  ACT_BEGIN_WRITE);   // unlocked: ignored
    issue_op(OP_UPDATE,    4'd0,  ACT_BEGIN_WRITE);
    issue_op(OP_CHECK,     4'd3,  ACT_WRITE);
    issue_op(OP_CHECK,     4'd3,  ACT_MAX);
    issue_op(OP_UNUSED_LO, 4'd3,  ACT_END);
    issue_op(OP_UNUSED_HI, 4'd15, ACT_MAX);
    issue_op(OP_RELEASE,   4'd3,  ACT_BEGIN_WRITE);
    issue_op(OP_UPDATE,    4'd15, ACT_MAX);
    issue_op(OP_CHECK,     4'd15, ACT_WRITE);
    issue_op(OP_RELEASE,   4'd15, ACT_BEGIN_WRITE);
  endtask

  // all clients become readers at once after a write phase
  task automatic test_full_read_burst();
    logic [CLIENT_W-1:0] w;
    logic [CLIENT_W-1:0] order [NCL];
    logic [CLIENT_W-1:0] t;
    int                  j;
    while (held_set != 0 || wr_cnt != 0 || rd_wait != 0) begin
      if (held_set != 0) issue_op(OP_RELEASE, pick_from(held_set), 3'($urandom));
      else issue_op(OP_UPDATE, CLIENT_W'($urandom), 3'($urandom));
    end
    w = CLIENT_W'($urandom);
    issue_op(OP_REQ_WRITE, w, 3'($urandom));
    for (int i = 0; i < NCL; i++) order[i] = i[CLIENT_W-1:0];
    for (int i = NCL - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < NCL; i++)
      if (order[i] != w) issue_op(OP_REQ_READ, order[i], 3'($urandom));
    issue_op(OP_RELEASE, w, 3'($urandom));
    issue_op(OP_REQ_READ, w, 3'($urandom));
  endtask

  task automatic test_writer_queue_full();
    while (wr_cnt < NCL) issue_op(OP_REQ_WRITE, CLIENT_W'($urandom), 3'($urandom));
    issue_op(OP_CHECK, wr_fifo[NCL-1], ACT_END);
    issue_op(OP_REQ_WRITE, 4'd0,  3'($urandom));
    issue_op(OP_REQ_WRITE, 4'd15, 3'($urandom));
    repeat (8) begin
      if (held_set != 0) issue_op(OP_RELEASE, pick_from(held_set), 3'($urandom));
      else issue_op(OP_UPDATE, CLIENT_W'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int                  r;
    logic [2:0]          op;
    logic [CLIENT_W-1:0] cl;
    logic [2:0]          act;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // alternate back-to-back stretches with gappy ones
      max_gap = ((k / 40) % 3 == 0) ? 0 : 4;
      r   = $urandom_range(0, 99);
      cl  = CLIENT_W'($urandom);
      act = 3'($urandom);
      if (r < 20) begin
        op = OP_REQ_WRITE;
      end else if (r < 45) begin
        op = OP_REQ_READ;
      end else if (r < 65) begin
        op = OP_RELEASE;
        if ($urandom_range(0, 3) != 0) cl = pick_from(held_set);
      end else if (r < 72) begin
        op = OP_FINISH;
        if ($urandom_range(0, 2) != 0) cl = pick_from(held_set);
      end else if (r < 90) begin
        op = OP_CHECK;
        if ($urandom_range(0, 1) != 0) cl = pick_from(held_set | rd_wait);
        if ($urandom_range(0, 6) != 0) act = 3'($urandom_range(ACT_BEGIN_WRITE, ACT_END));
        else act = 3'($urandom_range(ACT_END + 1, ACT_MAX));
      end else if (r < 97) begin
        op = OP_UPDATE;
      end else begin
        op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      issue_op(op, cl, act);
    end
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    rwla_out_t exp_r;
    if (rst_n && out_valid) begin
      case (out_item.kind)
        KIND_GRANT: grants_seen++;
        KIND_CHECK: checks_seen++;
        KIND_QFULL: drops_seen++;
        default: ;
      endcase
      if (lock_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: kind=%0d client=%0d wr=%0b ok=%0b last=%0b",
                   $time, out_item.kind, out_item.client_res, out_item.grant_write,
                   out_item.allowed, out_item.last);
      end else begin
        exp_r = lock_results_q[0];
        lock_results_q.delete(0);
        if (out_item.kind !== exp_r.kind || out_item.client_res !== exp_r.client_res ||
            out_item.grant_write !== exp_r.grant_write ||
            out_item.allowed !== exp_r.allowed || out_item.last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] mismatch: exp kind=%0d client=%0d wr=%0b ok=%0b last=%0b",
                     $time, exp_r.kind, exp_r.client_res, exp_r.grant_write,
                     exp_r.allowed, exp_r.last);
            $display("             got kind=%0d client=%0d wr=%0b ok=%0b last=%0b",
                     out_item.kind, out_item.client_res, out_item.grant_write,
                     out_item.allowed, out_item.last);
          end
        end
      end
    end
  end

  // stall watchdog: cycles in which neither a command nor a result is taken
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout after %0d idle cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    held_set    = '0;
    done_set    = '0;
    rd_wait     = '0;
    wr_cnt      = 0;
    write_phase = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_read_burst();
    test_writer_queue_full();
    test_random_traffic();

    start <= 1'b0;
    while (lock_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d grants, %0d check answers, %0d dropped write requests.",
             items_sent, grants_seen, checks_seen, drops_seen);
    $display("Largest grant burst %0d results; writer queue peaked at %0d entries.",
             max_burst, max_wr_cnt);
    if (mismatches == 0 && lock_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* readers_writer_lock_arbiter_top.f */
rtl/rwla_pkg.sv
rtl/rwla_wq_cell.sv
rtl/rwla_rd_cell.sv
rtl/readers_writer_lock_arbiter_top.sv
tb/readers_writer_lock_arbiter_top_tb.sv
